// File: rtl/aabb_build_and_ray_slab_test_defines.svh
// Assertion macros shared by the box and slab-test RTL.
`ifndef AABB_BUILD_AND_RAY_SLAB_TEST_DEFINES_SVH
`define AABB_BUILD_AND_RAY_SLAB_TEST_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge outside reset.
`define ABST_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Check that a condition at one edge implies another at the next edge.
`define ABST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ABST_ASSERT(lbl, clk, rst_n, cond)
`define ABST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/abst_pkg.sv
// Types and constants for the box builder and ray slab test.
`timescale 1ns / 1ps
package abst_pkg;
    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_W      = COORD_W + 1;
    localparam int QUOT_W     = COORD_W + FRAC_BITS;
    localparam int TIME_W     = QUOT_W + 2;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_CYCLES);
    localparam int AXES       = 3;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_FIRST = 2'd1;
    localparam logic [1:0] MODE_GROW  = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } in_word_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] t_entry;
    } out_word_t;

    typedef struct packed {
        logic [AXES-1:0][NUM_W-1:0]   num_lo;
        logic [AXES-1:0][NUM_W-1:0]   num_hi;
        logic [AXES-1:0][COORD_W-1:0] dir;
        logic                         miss;
    } query_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_FIN
    } back_state_t;
endpackage

// File: rtl/abst_front.sv
// Front end: accepts words, keeps the box, and forms slab queries.
`timescale 1ns / 1ps
module abst_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  abst_pkg::in_word_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output abst_pkg::query_t  q_entry
);
    import abst_pkg::*;

    logic [AXES-1:0][COORD_W-1:0] box_lo_reg, box_lo_next;
    logic [AXES-1:0][COORD_W-1:0] box_hi_reg, box_hi_next;
    logic [AXES-1:0][COORD_W-1:0] pos;
    logic [AXES-1:0][COORD_W-1:0] dir;
    logic                         accept;

    assign pos = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    assign dir = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;
    assign q_push = accept && (in_data.mode == MODE_QUERY);

    always_comb
    begin
        box_lo_next = box_lo_reg;
        box_hi_next = box_hi_reg;
        if (accept)
        begin
            unique case (in_data.mode)
                MODE_CLEAR:
                begin
                    box_lo_next = '0;
                    box_hi_next = '0;
                end
                MODE_FIRST:
                begin
                    box_lo_next = pos;
                    box_hi_next = pos;
                end
                MODE_GROW:
                begin
                    for (int a = 0; a < AXES; a++)
                    begin
                        if ($signed(pos[a]) < $signed(box_lo_reg[a]))
                            box_lo_next[a] = pos[a];
                        if ($signed(pos[a]) > $signed(box_hi_reg[a]))
                            box_hi_next[a] = pos[a];
                    end
                end
                MODE_QUERY:
                begin
                    box_lo_next = box_lo_reg;
                end
                default:
                begin
                    box_lo_next = box_lo_reg;
                end
            endcase
        end
    end

    // Form numerators against the current box; zero-direction axes are decided here.
    always_comb
    begin
        q_entry.miss = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            q_entry.num_lo[a] = NUM_W'($signed(box_lo_reg[a])) - NUM_W'($signed(pos[a]));
            q_entry.num_hi[a] = NUM_W'($signed(box_hi_reg[a])) - NUM_W'($signed(pos[a]));
            q_entry.dir[a]    = dir[a];
            if (dir[a] == '0 && ($signed(pos[a]) < $signed(box_lo_reg[a])
                                 || $signed(pos[a]) > $signed(box_hi_reg[a])))
                q_entry.miss = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_lo_reg <= '0;
            box_hi_reg <= '0;
        end
        else
        begin
            box_lo_reg <= box_lo_next;
            box_hi_reg <= box_hi_next;
        end
    end
endmodule

// File: rtl/abst_queue.sv
// Two-entry query queue between front and back.
`timescale 1ns / 1ps
module abst_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  abst_pkg::query_t push_data,
    input  logic             pop,
    output abst_pkg::query_t pop_data,
    output logic             full,
    output logic             empty
);
    import abst_pkg::*;

    query_t     slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end
endmodule

// File: rtl/abst_div.sv
// Restoring fixed-point divider, two quotient bits per cycle while run is high.
`timescale 1ns / 1ps
module abst_div (
    input  logic                                clk,
    input  logic                                start,
    input  logic                                run,
    input  logic signed [abst_pkg::NUM_W-1:0]   num,
    input  logic signed [abst_pkg::COORD_W-1:0] den,
    output logic signed [abst_pkg::TIME_W-1:0]  quot
);
    import abst_pkg::*;

    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0]  dvd_reg, dvd_next;
    logic [COORD_W-1:0] den_reg;
    logic               neg_reg;
    logic [NUM_W-1:0]   num_mag;
    logic [NUM_W-1:0]   den_mag;
    logic [NUM_W-1:0]   trial;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[COORD_W-1] ? -NUM_W'(den) : NUM_W'(den);

    // Shift dividend bits into the remainder; quotient bits fill in behind.
    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        trial    = '0;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial    = {rem_next, dvd_next[QUOT_W-1]};
            dvd_next = {dvd_next[QUOT_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                dvd_next[0] = 1'b1;
            end
            rem_next = trial[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= {num_mag[COORD_W-1:0], {FRAC_BITS{1'b0}}};
            den_reg <= den_mag[COORD_W-1:0];
            neg_reg <= num[NUM_W-1] ^ den[COORD_W-1];
        end
        else if (run)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign quot = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
endmodule

// File: rtl/abst_back.sv
// Back end: per-axis divisions, entry/exit reduction, result register.
`timescale 1ns / 1ps
module abst_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  abst_pkg::query_t   q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output abst_pkg::out_word_t out_data
);
    import abst_pkg::*;

    localparam logic signed [TIME_W-1:0] T_POS = TIME_W'(1) << QUOT_W;
    localparam logic signed [TIME_W-1:0] T_NEG = -T_POS;
    localparam logic signed [TIME_W-1:0] SAT_HI =
        {{(TIME_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] SAT_LO = ~SAT_HI;

    back_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [AXES-1:0]           dzero_reg;
    logic                      miss_reg;
    logic                      out_valid_reg;
    out_word_t                 out_reg;
    logic                      start, run, load_out;
    logic signed [TIME_W-1:0]  q_lo [AXES];
    logic signed [TIME_W-1:0]  q_hi [AXES];
    logic signed [TIME_W-1:0]  t_near, t_far, lo, hi, te;
    logic                      hit;

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        abst_div u_div_lo (
            .clk  (clk),
            .start(start),
            .run  (run),
            .num  ($signed(q_data.num_lo[a])),
            .den  ($signed(q_data.dir[a])),
            .quot (q_lo[a])
        );
        abst_div u_div_hi (
            .clk  (clk),
            .start(start),
            .run  (run),
            .num  ($signed(q_data.num_hi[a])),
            .den  ($signed(q_data.dir[a])),
            .quot (q_hi[a])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_RUN;
            BK_RUN:  if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) state_next = BK_FIN;
            BK_FIN:  if (!out_valid_reg || out_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        start    = 1'b0;
        run      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: start = !q_empty;
            BK_RUN:  run = 1'b1;
            BK_FIN:  load_out = !out_valid_reg || out_ready;
            default: start = 1'b0;
        endcase
    end

    assign q_pop = start;

    always_comb
    begin
        t_near = T_NEG;
        t_far  = T_POS;
        for (int a = 0; a < AXES; a++)
        begin
            lo = (q_lo[a] < q_hi[a]) ? q_lo[a] : q_hi[a];
            hi = (q_lo[a] < q_hi[a]) ? q_hi[a] : q_lo[a];
            if (!dzero_reg[a])
            begin
                if (lo > t_near)
                    t_near = lo;
                if (hi < t_far)
                    t_far = hi;
            end
        end
        hit = !miss_reg && (t_far >= t_near) && (t_far > 0);
        te = t_near;
        if (te > SAT_HI)
            te = SAT_HI;
        if (te < SAT_LO)
            te = SAT_LO;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            miss_reg <= q_data.miss;
            for (int a = 0; a < AXES; a++)
                dzero_reg[a] <= (q_data.dir[a] == '0);
        end
        if (load_out)
        begin
            out_reg.hit     <= hit;
            out_reg.t_entry <= te[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
                cnt_reg <= '0;
            else if (run)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// File: rtl/aabb_build_and_ray_slab_test.sv
// Top level of the bounding-box builder and ray slab tester.
`timescale 1ns / 1ps
`include "aabb_build_and_ray_slab_test_defines.svh"
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one word per item.
//   Mode 0 clears the box, mode 1 starts it at a vertex, mode 2 widens it by a
//   vertex; these give no result word and take effect in the next cycle.
//   Mode 3 is a ray query: origin in pos_*, direction in dir_*, Q16.16.
//   Each query gives one output word (out_valid/out_ready/out_data) with hit
//   and the saturated entry time.
//   A query goes from acceptance through the queue entry, the division in six
//   parallel radix-4 dividers for the 48-bit quotients and the reduction to
//   out_valid. The back end works on one query at a time. Box updates are
//   taken every cycle meanwhile, while in_ready is high (queue not full).
//   A two-entry queue sits between the front and the dividers, so the front
//   keeps accepting while a query is computed; in_ready drops when it is full.
//   A result waiting on a stalled receiver holds in the output register; the
//   next query then holds in its final stage until the register frees.
//   Reset clears the box to zero, empties the queue and drops out_valid.
module aabb_build_and_ray_slab_test (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  abst_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output abst_pkg::out_word_t out_data
);
    import abst_pkg::*;

    query_t      push_data, pop_data;
    queue_stat_t qs;

    // Front: hold the box, form queries.
    abst_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data (in_data),
        .q_full  (qs.full),
        .q_push  (qs.push),
        .q_entry (push_data)
    );

    // Decouple front and back.
    abst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (qs.push),
        .push_data(push_data),
        .pop      (qs.pop),
        .pop_data (pop_data),
        .full     (qs.full),
        .empty    (qs.empty)
    );

    // Back: divide, reduce, deliver.
    abst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (qs.empty),
        .q_data   (pop_data),
        .q_pop    (qs.pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    `ABST_ASSERT(a_no_push_full, clk, rst_n, !(qs.push && qs.full))
    `ABST_ASSERT(a_no_pop_empty, clk, rst_n, !(qs.pop && qs.empty))
    `ABST_ASSERT_NEXT(a_push_fills, clk, rst_n, qs.push && !qs.pop, !qs.empty)
endmodule
